/* src/lir_pkg.sv */
// lir_pkg: shared types and constants of the linear interpolation resampler
// no dependencies
package lir_pkg;

	// command kind carried from the front to the back
	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_kind_t;

	// longest run of outputs caused by one input item
	localparam int MAX_RUN = 16;
	localparam int RUN_CNT_W = $clog2(MAX_RUN);

	// skip counter
	localparam int SKIP_W = 5;
	localparam logic [SKIP_W-1:0] SKIP_MAX = '1;

	// integer part of phase plus step, step has five integer bits
	localparam int WHOLE_W = 6;

	// extra integer bits of the step register over the fraction
	localparam int STEP_INT_W = 5;

	// valid and ready handshake at the head of the queue between front and back
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage

/* src/lir_queue.sv */
// lir_queue: two-entry queue of commands between front and back
// uses lir_pkg for the handshake struct
module lir_queue #(
	parameter int DW = 33
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DW-1:0]     push_data,
	output lir_pkg::hs_t      pop_hs_o,
	input  logic              pop_ready,
	output logic [DW-1:0]     pop_data
);

	logic [DW-1:0] mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	// handshake on both sides
	assign push_ready     = (count_q != 2'd2);
	assign do_push        = push_valid && push_ready;
	assign do_pop         = (count_q != 2'd0) && pop_ready;
	assign pop_hs_o.valid = (count_q != 2'd0);
	assign pop_hs_o.ready = pop_ready;
	assign pop_data       = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/lir_front.sv */
// lir_front: accepts input items, keeps sample history, classifies each item
// uses lir_pkg for the command kind
module lir_front #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
	input  logic                           restart,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output logic [2*SAMPLE_WIDTH:0]        cmd_data
);

	logic                    have_prev_q;
	logic [SAMPLE_WIDTH-1:0] prev_q;
	lir_pkg::cmd_kind_t      kind;
	logic                    accept;

	// item goes straight into the queue
	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign accept    = in_valid && cmd_ready;

	// a new stream starts without history or on restart
	assign kind     = (!have_prev_q || restart) ? lir_pkg::CMD_START : lir_pkg::CMD_DATA;
	assign cmd_data = {kind, prev_q, in_sample};

	// history flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (accept) begin
			have_prev_q <= 1'b1;
		end
	end

	// previous sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (accept) begin
			prev_q <= in_sample;
		end
	end

endmodule

/* src/lir_back.sv */
// lir_back: phase accumulator, skip counter and interpolation pipeline
// uses lir_pkg for command kind, run limit and counter widths
module lir_back #(
	parameter int SAMPLE_WIDTH  = 16,
	parameter int FRACTION_BITS = 32
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic [FRACTION_BITS+lir_pkg::STEP_INT_W-1:0]   step_q,
	input  lir_pkg::hs_t                                   cmd_hs_i,
	output logic                                           cmd_ready,
	input  logic [2*SAMPLE_WIDTH:0]                        cmd_data,
	output logic                                           out_valid,
	input  logic                                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]                 out_sample,
	output logic                                           last_in_run
);

	localparam int POS_W  = FRACTION_BITS + lir_pkg::WHOLE_W;
	localparam int PROD_W = SAMPLE_WIDTH + FRACTION_BITS + 2;

	lir_pkg::cmd_kind_t                kind;
	logic [SAMPLE_WIDTH-1:0]           prev;
	logic [SAMPLE_WIDTH-1:0]           cur;
	logic [FRACTION_BITS-1:0]          phase_q;
	logic [lir_pkg::SKIP_W-1:0]        skip_q;
	logic [lir_pkg::RUN_CNT_W-1:0]     cnt_q;
	logic signed [SAMPLE_WIDTH:0]      diff;
	logic signed [PROD_W-1:0]          prod;
	logic [POS_W-1:0]                  pos;
	logic [lir_pkg::WHOLE_W-1:0]       whole;
	logic [lir_pkg::WHOLE_W-1:0]       whole_m1;
	logic                              adv;
	logic                              take;
	logic                              emit;
	logic                              run_end;
	logic                              stop_whole;
	logic                              stop_limit;
	logic                              s1_valid_q;
	logic signed [PROD_W-1:0]          prod_s1;
	logic [SAMPLE_WIDTH-1:0]           prev_s1;
	logic                              last_s1;
	logic signed [PROD_W-1:0]          shifted;
	logic                              out_valid_q;
	logic [SAMPLE_WIDTH-1:0]           out_sample_q;
	logic                              last_q;

	// unpack the command at the head of the queue
	assign kind = lir_pkg::cmd_kind_t'(cmd_data[2*SAMPLE_WIDTH]);
	assign prev = cmd_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
	assign cur  = cmd_data[SAMPLE_WIDTH-1:0];

	// pipeline moves when the product stage is empty or the output register frees up
	assign adv  = !s1_valid_q || !out_valid_q || out_ready;
	assign take = cmd_hs_i.valid && adv;
	assign emit = take && (kind == lir_pkg::CMD_DATA) && (skip_q == '0);

	// product of sample difference and phase
	assign diff = $signed({cur[SAMPLE_WIDTH-1], cur}) - $signed({prev[SAMPLE_WIDTH-1], prev});
	assign prod = diff * $signed({1'b0, phase_q});

	// next output position
	assign pos        = POS_W'(phase_q) + POS_W'(step_q);
	assign whole      = pos[POS_W-1:FRACTION_BITS];
	assign whole_m1   = whole - lir_pkg::WHOLE_W'(1);
	assign stop_whole = (whole != '0);
	assign stop_limit = (cnt_q == lir_pkg::RUN_CNT_W'(lir_pkg::MAX_RUN - 1));
	assign run_end    = stop_whole || stop_limit;

	// command leaves the queue once it is fully handled
	assign cmd_ready = take && ((kind == lir_pkg::CMD_START) || (skip_q != '0) || run_end);

	// phase, skip and run count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			skip_q  <= '0;
			cnt_q   <= '0;
		end else if (take) begin
			if (kind == lir_pkg::CMD_START) begin
				phase_q <= '0;
				skip_q  <= '0;
				cnt_q   <= '0;
			end else if (skip_q != '0) begin
				skip_q <= skip_q - lir_pkg::SKIP_W'(1);
			end else if (stop_whole) begin
				phase_q <= pos[FRACTION_BITS-1:0];
				cnt_q   <= '0;
				if (whole_m1 > lir_pkg::WHOLE_W'(lir_pkg::SKIP_MAX)) begin
					skip_q <= lir_pkg::SKIP_MAX;
				end else begin
					skip_q <= whole_m1[lir_pkg::SKIP_W-1:0];
				end
			end else if (stop_limit) begin
				cnt_q  <= '0;
				skip_q <= '0;
			end else begin
				phase_q <= pos[FRACTION_BITS-1:0];
				cnt_q   <= cnt_q + lir_pkg::RUN_CNT_W'(1);
			end
		end
	end

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			prod_s1 <= prod;
			prev_s1 <= prev;
			last_s1 <= run_end;
		end
	end

	// floored shift and add, truncated to the sample width
	assign shifted = prod_s1 >>> FRACTION_BITS;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && (!out_valid_q || out_ready)) begin
			out_sample_q <= prev_s1 + shifted[SAMPLE_WIDTH-1:0];
			last_q       <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = $signed(out_sample_q);
	assign last_in_run = last_q;

endmodule

/* src/linear_interp_resampler.sv */
// linear_interp_resampler: streaming mono resampler by linear interpolation
// an accepted item passes the queue entry, the product stage and the output register
// before its first output item; throughput: one output item per cycle while out_ready
// is high; a run of n outputs occupies the back end until it ends, start and skip items emit none
// the two-entry command queue lets input items enter while a run is emitted
// reset: history, phase, skip count and queue clear, step returns to 1.0
module linear_interp_resampler #(
	parameter int SAMPLE_WIDTH  = 16,
	parameter int FRACTION_BITS = 32
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [FRACTION_BITS+lir_pkg::STEP_INT_W-1:0]  step_size,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]                in_sample,
	input  logic                                          restart,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]                out_sample,
	output logic                                          last_in_run
);

	localparam int STEP_W = FRACTION_BITS + lir_pkg::STEP_INT_W;
	localparam int CMD_W  = 2 * SAMPLE_WIDTH + 1;

	logic [STEP_W-1:0] step_q;
	logic              front_valid;
	logic              front_ready;
	logic [CMD_W-1:0]  front_data;
	lir_pkg::hs_t      head_hs;
	logic              head_pop;
	logic [CMD_W-1:0]  head_data;

	// step register, reset to ratio one
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_W'(1) << FRACTION_BITS;
		end else if (cfg_valid && cfg_ready) begin
			step_q <= step_size;
		end
	end

	// front: history and classification
	lir_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_sample (in_sample),
		.restart   (restart),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd_data  (front_data)
	);

	// command queue
	lir_queue #(
		.DW(CMD_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_data),
		.pop_hs_o   (head_hs),
		.pop_ready  (head_pop),
		.pop_data   (head_data)
	);

	// back: phase stepping and interpolation
	lir_back #(
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_q      (step_q),
		.cmd_hs_i    (head_hs),
		.cmd_ready   (head_pop),
		.cmd_data    (head_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_sample  (out_sample),
		.last_in_run (last_in_run)
	);

endmodule
